// File: rtl/fmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmw_pkg;

  // Payload widths
  localparam int unsigned WordW = 32;
  localparam int unsigned SumW  = 8;

  // Fletcher modulus
  localparam logic [SumW-1:0] Mod = 8'd255;

  // Classified word as it travels from front to back.
  // A word w contributes (w mod 255) to the low sum, minus one when the
  // 32-bit add with the running low sum wraps. The wrap can only happen
  // when bits 31..8 are all ones, and then depends on the low byte alone.
  typedef struct packed {
    logic [SumW-1:0] word_mod;   // word mod 255
    logic [7:0]      low_byte;   // word[7:0], for the wrap check
    logic            top_ones;   // word[31:8] all ones
    logic            last;       // final word of the record
  } item_t;

endpackage

`default_nettype wire

// File: rtl/fmw_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Word request channel
interface fmw_word_if;
  logic                           valid;
  logic                           ready;
  logic [fmw_pkg::WordW-1:0]      word;
  logic                           last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

// Checksum request channel
interface fmw_sum_if;
  logic                           valid;
  logic                           ready;
  logic [fmw_pkg::SumW-1:0]       sum_low;
  logic [fmw_pkg::SumW-1:0]       sum_high;

  modport source (output valid, output sum_low, output sum_high, input ready);
  modport sink   (input valid, input sum_low, input sum_high, output ready);
endinterface

`default_nettype wire

// File: rtl/fmw_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front: takes words and reduces each one modulo 255 ahead of the queue.
module fmw_front (
  fmw_word_if.sink       in_i,
  input  wire logic      q_ready_i,
  output fmw_pkg::item_t item_o,
  output logic           push_o
);

  logic [9:0] byte_sum;
  logic [8:0] fold1;
  logic [7:0] fold2;

  // 256 == 1 (mod 255): add the bytes, then fold the carries back in
  always_comb begin
    byte_sum = {2'b00, in_i.word[7:0]}   + {2'b00, in_i.word[15:8]} +
               {2'b00, in_i.word[23:16]} + {2'b00, in_i.word[31:24]};
    fold1    = {1'b0, byte_sum[7:0]} + {7'b0, byte_sum[9:8]};
    fold2    = fold1[7:0] + {7'b0, fold1[8]};
  end

  // Classified item
  always_comb begin
    item_o.word_mod = (fold2 == fmw_pkg::Mod) ? '0 : fold2;
    item_o.low_byte = in_i.word[7:0];
    item_o.top_ones = &in_i.word[31:8];
    item_o.last     = in_i.last_word;
  end

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

endmodule

`default_nettype wire

// File: rtl/fmw_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Short queue between front and back; push and pop in the same cycle.
module fmw_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire fmw_pkg::item_t item_i,
  output logic                ready_o,
  output logic                valid_o,
  output fmw_pkg::item_t      item_o,
  input  wire logic           pop_i
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fmw_pkg::item_t  mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("fifo count above depth");

  a_cnt_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("fifo count did not drop on pop");

endmodule

`default_nettype wire

// File: rtl/fmw_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Back: folds queued items into the running sums and holds the result.
module fmw_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire fmw_pkg::item_t item_i,
  output logic                pop_o,
  fmw_sum_if.source           out_o
);

  logic [fmw_pkg::SumW-1:0] run_low_q, run_high_q;
  logic [fmw_pkg::SumW-1:0] out_low_q, out_high_q;
  logic                     out_valid_q;

  logic [8:0]               byte_add;
  logic                     wrap;
  logic [8:0]               low_raw;
  logic [8:0]               high_raw;
  logic [fmw_pkg::SumW-1:0] low_new;
  logic [fmw_pkg::SumW-1:0] high_new;
  logic                     out_free;

  // Next sums; a 32-bit wrap removes 2^32, which is 1 mod 255
  always_comb begin
    byte_add = {1'b0, item_i.low_byte} + {1'b0, run_low_q};
    wrap     = item_i.top_ones && byte_add[8];
    low_raw  = {1'b0, item_i.word_mod} + {1'b0, run_low_q} - {8'b0, wrap};
    low_new  = (low_raw >= {1'b0, fmw_pkg::Mod}) ? 8'(low_raw - {1'b0, fmw_pkg::Mod})
                                                 : low_raw[7:0];
    high_raw = {1'b0, run_high_q} + {1'b0, low_new};
    high_new = (high_raw >= {1'b0, fmw_pkg::Mod}) ? 8'(high_raw - {1'b0, fmw_pkg::Mod})
                                                  : high_raw[7:0];
  end

  // A last word needs a free output slot; others go straight through
  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o    = valid_i && (!item_i.last || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_low_q   <= '0;
      run_high_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (item_i.last) begin
          run_low_q   <= '0;
          run_high_q  <= '0;
          out_valid_q <= 1'b1;
        end else begin
          run_low_q  <= low_new;
          run_high_q <= high_new;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      out_low_q  <= low_new;
      out_high_q <= high_new;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.sum_low  = out_low_q;
  assign out_o.sum_high = out_high_q;

  // Checks
  a_sums_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_low_q != fmw_pkg::Mod) && (run_high_q != fmw_pkg::Mod))
    else $error("running sum not reduced");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.last) |=> (out_valid_q && run_low_q == '0 && run_high_q == '0))
    else $error("record end not handled");

endmodule

`default_nettype wire

// File: rtl/fletcher_mod255_word_checksum.sv
`timescale 1ns / 1ps
`default_nettype none

// Fletcher-style checksum over records of 32-bit words, both sums mod 255.
// in_i  : one word per request; last_word marks the final word of a record.
//         The low sum adds the word with 32-bit wraparound, then reduces
//         mod 255; the high sum adds the new low sum mod 255.
// out_o : one request per record carrying sum_low and sum_high
//         (packed checksum is sum_high << 8 | sum_low).
// Throughput: one word per cycle, set by the back end's fold of one queued
// word into the running sums; a last word waits while the output is not free.
// The last word is stored in the queue, then folded by the back end into the
// output register, which offers the result to the receiver; this path holds
// when the queue is empty and the output register is free.
// A word is reduced mod 255 in the front, queued in a FIFO_DEPTH entry
// queue, and folded in by the back end, which owns the output register.
// Receiver stall: the result holds in the output register; words that are
// not last keep flowing, and the queue fills only behind a pending last word.
// Reset clears both running sums, the queue and the output valid.
module fletcher_mod255_word_checksum #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fmw_word_if.sink   in_i,
  fmw_sum_if.source  out_o
);

  fmw_pkg::item_t front_item;
  fmw_pkg::item_t head_item;
  logic           push;
  logic           q_ready;
  logic           head_valid;
  logic           pop;

  fmw_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .item_o    (front_item),
    .push_o    (push)
  );

  fmw_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .valid_o (head_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  fmw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
